// ----- rtl/spct_pkg.sv -----
// shared types and constants for the shape pair collision test
// no dependencies; imported by spct_prep and the top level
package spct_pkg;

   localparam int KIND_W = 2;
   localparam int SIZE_W = 12;
   localparam int HALF_W = SIZE_W - 1;
   localparam int RAD_W  = SIZE_W + 1;
   localparam int SQ_W   = 2 * RAD_W;
   localparam int SSUM_W = SQ_W + 1;

   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RECT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd2;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_RR   = 2'd1,
      MODE_RC   = 2'd2,
      MODE_CC   = 2'd3
   } mode_type;

   // pair classification from kinds and sizes
   typedef struct packed {
      mode_type          mode;
      logic [SIZE_W-1:0] sum_w;
      logic [SIZE_W-1:0] sum_h;
      logic [RAD_W-1:0]  rad;
   } prep_type;

   // outcome of the range checks, ahead of the squaring stage
   typedef struct packed {
      logic             decided;
      logic             decided_hit;
      logic             strict;
      logic [RAD_W-1:0] ex;
      logic [RAD_W-1:0] ey;
      logic [RAD_W-1:0] rad;
   } range_type;

endpackage

// ----- rtl/spct_prep.sv -----
// pair classification: picks the test and folds the half sizes and radii
// depends on spct_pkg
module spct_prep (
   input  logic [spct_pkg::KIND_W-1:0] kind_a,
   input  logic [spct_pkg::SIZE_W-1:0] w_a,
   input  logic [spct_pkg::SIZE_W-1:0] h_a,
   input  logic [spct_pkg::KIND_W-1:0] kind_b,
   input  logic [spct_pkg::SIZE_W-1:0] w_b,
   input  logic [spct_pkg::SIZE_W-1:0] h_b,
   output spct_pkg::prep_type          prep
);
   import spct_pkg::*;

   logic [HALF_W-1:0] hw_a, hh_a, hw_b, hh_b;

   assign hw_a = w_a[SIZE_W-1:1];
   assign hh_a = h_a[SIZE_W-1:1];
   assign hw_b = w_b[SIZE_W-1:1];
   assign hh_b = h_b[SIZE_W-1:1];

   always_comb begin
      prep.mode  = MODE_NONE;
      prep.sum_w = '0;
      prep.sum_h = '0;
      prep.rad   = '0;
      if (kind_a == KIND_RECT && kind_b == KIND_RECT) begin
         prep.mode  = MODE_RR;
         prep.sum_w = SIZE_W'(hw_a) + SIZE_W'(hw_b);
         prep.sum_h = SIZE_W'(hh_a) + SIZE_W'(hh_b);
      end else if (kind_a == KIND_RECT && kind_b == KIND_CIRCLE) begin
         prep.mode  = MODE_RC;
         prep.sum_w = SIZE_W'(hw_a);
         prep.sum_h = SIZE_W'(hh_a);
         prep.rad   = RAD_W'(w_b);
      end else if (kind_a == KIND_CIRCLE && kind_b == KIND_RECT) begin
         prep.mode  = MODE_RC;
         prep.sum_w = SIZE_W'(hw_b);
         prep.sum_h = SIZE_W'(hh_b);
         prep.rad   = RAD_W'(w_a);
      end else if (kind_a == KIND_CIRCLE && kind_b == KIND_CIRCLE) begin
         // circles meet below the sum of radii, box offsets stay zero
         prep.mode = MODE_CC;
         prep.rad  = RAD_W'(w_a) + RAD_W'(w_b);
      end
   end

endmodule

// ----- rtl/shape_pair_collision_test_top.sv -----
// top level of the shape pair collision test: four-stage hit pipeline
// depends on spct_pkg and spct_prep
//
// usage:
//   one request carries two shapes (centre, kind, width, height; width is
//   the radius for a circle) and gives one response with a hit flag
//   request channel: req_valid / req_stall, taken when valid and not stall
//   response channel: rsp_valid / rsp_stall, same rule, stall from receiver
//   throughput: one request per cycle, sustained, with no stall at output
//   stages: centre offsets and pair folding, range checks, three parallel
//   squarers, then the distance sum and compare
//   stall: each stage holds only while it is full and the stage after it
//   holds, so bubbles close up and up to four requests are held, the waiting
//   response among them; req_stall is high when all four are full and stalled
//   reset: synchronous, clears every stage valid; responses in flight are
//   dropped and no response appears until a new request is taken
module shape_pair_collision_test_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic [spct_pkg::KIND_W-1:0]   req_first_kind,
   input  logic [spct_pkg::SIZE_W-1:0]   req_first_w,
   input  logic [spct_pkg::SIZE_W-1:0]   req_first_h,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic [spct_pkg::KIND_W-1:0]   req_second_kind,
   input  logic [spct_pkg::SIZE_W-1:0]   req_second_w,
   input  logic [spct_pkg::SIZE_W-1:0]   req_second_h,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit
);
   import spct_pkg::*;

   localparam int DW = (COORD_WIDTH > RAD_W) ? COORD_WIDTH : RAD_W + 1;

   // stage enables
   logic en1, en2, en3, en4;

   // stage 1
   logic                   v1_ff;
   logic [COORD_WIDTH-1:0] dx_ff, dy_ff, dx_in, dy_in;
   prep_type               prep_ff, prep_in;

   // stage 2
   logic      v2_ff;
   range_type rng_ff, rng_in;

   // stage 3
   logic            v3_ff;
   logic            dec3_ff, dhit3_ff, strict3_ff;
   logic [SQ_W-1:0] exsq_ff, eysq_ff, rsq_ff;

   // stage 4
   logic v4_ff;
   logic hit_ff, hit_in;

   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   // absolute centre offsets, always fit the coordinate width unsigned
   always_comb begin
      logic signed [COORD_WIDTH:0] ax, bx, ay, by;
      ax = {req_first_x[COORD_WIDTH-1], req_first_x};
      bx = {req_second_x[COORD_WIDTH-1], req_second_x};
      ay = {req_first_y[COORD_WIDTH-1], req_first_y};
      by = {req_second_y[COORD_WIDTH-1], req_second_y};
      if (ax > bx) dx_in = COORD_WIDTH'(ax - bx);
      else         dx_in = COORD_WIDTH'(bx - ax);
      if (ay > by) dy_in = COORD_WIDTH'(ay - by);
      else         dy_in = COORD_WIDTH'(by - ay);
   end

   spct_prep u_prep (
      .kind_a (req_first_kind),
      .w_a    (req_first_w),
      .h_a    (req_first_h),
      .kind_b (req_second_kind),
      .w_b    (req_second_w),
      .h_b    (req_second_h),
      .prep   (prep_in)
   );

   // range checks; only undecided circle pairs and box corners go on to the squarers
   always_comb begin
      logic [DW-1:0] dxw, dyw, bw, bh, rw, reach_w, reach_h;
      dxw     = DW'(dx_ff);
      dyw     = DW'(dy_ff);
      bw      = DW'(prep_ff.sum_w);
      bh      = DW'(prep_ff.sum_h);
      rw      = DW'(prep_ff.rad);
      reach_w = bw + rw;
      reach_h = bh + rw;
      rng_in.decided     = 1'b1;
      rng_in.decided_hit = 1'b0;
      rng_in.strict      = 1'b0;
      rng_in.ex          = '0;
      rng_in.ey          = '0;
      rng_in.rad         = prep_ff.rad;
      case (prep_ff.mode)
         MODE_RR: begin
            rng_in.decided_hit = (dxw <= bw) && (dyw <= bh);
         end
         MODE_RC: begin
            if (dxw > reach_w || dyw > reach_h) begin
               rng_in.decided_hit = 1'b0;
            end else if (dxw <= bw || dyw <= bh) begin
               rng_in.decided_hit = 1'b1;
            end else begin
               // corner region: distance from the box corner
               rng_in.decided = 1'b0;
               rng_in.ex      = RAD_W'(dxw - bw);
               rng_in.ey      = RAD_W'(dyw - bh);
            end
         end
         MODE_CC: begin
            if (!(dxw >= rw || dyw >= rw)) begin
               rng_in.decided = 1'b0;
               rng_in.strict  = 1'b1;
               rng_in.ex      = RAD_W'(dxw);
               rng_in.ey      = RAD_W'(dyw);
            end
         end
         default: begin
            rng_in.decided_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic [SSUM_W-1:0] ssum, rsq;
      ssum = SSUM_W'(exsq_ff) + SSUM_W'(eysq_ff);
      rsq  = SSUM_W'(rsq_ff);
      if (dec3_ff)         hit_in = dhit3_ff;
      else if (strict3_ff) hit_in = ssum < rsq;
      else                 hit_in = ssum <= rsq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         prep_ff <= prep_in;
      end
      if (en2) begin
         rng_ff <= rng_in;
      end
      if (en3) begin
         dec3_ff    <= rng_ff.decided;
         dhit3_ff   <= rng_ff.decided_hit;
         strict3_ff <= rng_ff.strict;
         exsq_ff    <= rng_ff.ex * rng_ff.ex;
         eysq_ff    <= rng_ff.ey * rng_ff.ey;
         rsq_ff     <= rng_ff.rad * rng_ff.rad;
      end
      if (en4) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_hit   = hit_ff;

endmodule

// ----- rtl/spct_checker.sv -----
// port-level checks for the shape pair collision test, bound to the top
// depends on shape_pair_collision_test_top ports only
module spct_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_hit
);

   // a held response keeps its flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("response changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // requests back up only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with output free");

   // a response leaving frees room for a request
   a_drain_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> !req_stall)
      else $error("request stalled while response drains");

endmodule

bind shape_pair_collision_test_top spct_checker u_checker (.*);
